// File: design/tbmn_pkg.sv
`default_nettype none

package tbmn_pkg;

  localparam int unsigned TimeW       = 48;
  localparam int unsigned CfgW        = 24;
  localparam int unsigned MenuEntries = 8;
  localparam int unsigned AssistApp   = 0;

  localparam logic [3:0] SelLast  = 4'(MenuEntries - 1);
  localparam logic [3:0] AppAssist = 4'(AssistApp);

  typedef enum logic [1:0] {
    SCREEN_HOME = 2'd0,
    SCREEN_MENU = 2'd1,
    SCREEN_APP  = 2'd2
  } screen_e;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_HOME_MENU = 4'd1,
    EV_SEL_UP    = 4'd2,
    EV_SEL_DOWN  = 4'd3,
    EV_OPEN_SEL  = 4'd4,
    EV_FORWARD   = 4'd5,
    EV_APP_MENU  = 4'd6,
    EV_MENU_HOME = 4'd7,
    EV_ASSIST    = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    CFG_BACK_HOLD       = 2'd0,
    CFG_HOME_HOLD       = 2'd1,
    CFG_REPEAT_DELAY    = 2'd2,
    CFG_REPEAT_INTERVAL = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BUTTON_LEFT   = 2'd0,
    BUTTON_MIDDLE = 2'd1,
    BUTTON_RIGHT  = 2'd2
  } button_e;

  // Classified poll as it travels from the front to the back.
  typedef struct packed {
    logic left_click;
    logic right_click;
    logic mid_pressed;
    logic mid_prev;
    logic mid_gt_home;
    logic mid_gt_back;
  } cls_t;

endpackage

`default_nettype wire

// File: design/three_button_menu_navigator_unit.sv
`default_nettype none

// Three-button menu navigator. Each input beat is one poll of the left, middle and right
// buttons (active low) with a 48-bit microsecond timestamp; each poll yields three result
// beats, left, middle, right, the last one flagged by last_of_poll_o. The front classifies
// a poll in the cycle it is accepted (press edges, hold and auto-repeat timing against the
// four configuration registers) and pushes it into a two-entry queue; the back walks the
// screen machine one button per cycle, while the queue holds a poll and the output register
// is free or being taken, into an output register. A poll is accepted in any cycle the
// queue has room, so a new poll can be taken before the last one's results are out; the
// single result port, one button per beat, sets the throughput. Configuration writes take
// effect at the next clock edge and should be made only while no poll is in flight.
module three_button_menu_navigator_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [tbmn_pkg::TimeW-1:0]  time_now_us_i,
  input  wire logic                        left_level_i,
  input  wire logic                        middle_level_i,
  input  wire logic                        right_level_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [tbmn_pkg::CfgW-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       button_index_o,
  output logic [3:0]                       event_code_o,
  output logic [1:0]                       screen_after_o,
  output logic [3:0]                       menu_selection_o,
  output logic [3:0]                       active_app_o,
  output logic                             last_of_poll_o
);
  import tbmn_pkg::*;

  cls_t front_cls, head_cls;
  logic q_full, q_valid, q_pop, accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  tbmn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .time_now_us_i  (time_now_us_i),
    .left_level_i   (left_level_i),
    .middle_level_i (middle_level_i),
    .right_level_i  (right_level_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cls_o          (front_cls)
  );

  tbmn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_cls),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_cls)
  );

  tbmn_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cls_valid_i      (q_valid),
    .cls_i            (head_cls),
    .cls_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .button_index_o   (button_index_o),
    .event_code_o     (event_code_o),
    .screen_after_o   (screen_after_o),
    .menu_selection_o (menu_selection_o),
    .active_app_o     (active_app_o),
    .last_of_poll_o   (last_of_poll_o)
  );

endmodule

`default_nettype wire

// File: design/tbmn_front.sv
`default_nettype none

module tbmn_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [tbmn_pkg::TimeW-1:0]  time_now_us_i,
  input  wire logic                        left_level_i,
  input  wire logic                        middle_level_i,
  input  wire logic                        right_level_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [tbmn_pkg::CfgW-1:0]   cfg_data_i,
  output tbmn_pkg::cls_t                   cls_o
);
  import tbmn_pkg::*;

  logic [CfgW-1:0]  back_hold_q, home_hold_q, rep_delay_q, rep_intv_q;
  logic [2:0]       prev_q;
  logic [TimeW-1:0] start_q [3];
  logic [TimeW-1:0] start_d [3];
  logic [TimeW-1:0] held    [3];
  // Last repeat time of the two side buttons: index 0 left, 1 right.
  logic [TimeW-1:0] last_q  [2];
  logic [TimeW-1:0] since_rep [2];
  logic [1:0]       rep;
  logic [2:0]       pressed;
  logic [2:0]       rise;

  assign pressed = ~{right_level_i, middle_level_i, left_level_i};
  assign rise    = pressed & ~prev_q;

  // A fresh press restarts the hold timer at this poll, so its hold time is zero.
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      start_d[b] = rise[b] ? time_now_us_i : start_q[b];
      held[b]    = time_now_us_i - start_d[b];
    end
  end

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      since_rep[s] = time_now_us_i - last_q[s];
      rep[s] = pressed[2*s] && (held[2*s] > {{(TimeW-CfgW){1'b0}}, rep_delay_q})
               && (since_rep[s] > {{(TimeW-CfgW){1'b0}}, rep_intv_q});
    end
  end

  always_comb begin
    cls_o.left_click  = rise[0] | rep[0];
    cls_o.right_click = rise[2] | rep[1];
    cls_o.mid_pressed = pressed[1];
    cls_o.mid_prev    = prev_q[1];
    cls_o.mid_gt_home = held[1] > {{(TimeW-CfgW){1'b0}}, home_hold_q};
    cls_o.mid_gt_back = held[1] > {{(TimeW-CfgW){1'b0}}, back_hold_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_hold_q <= CfgW'(600000);
      home_hold_q <= CfgW'(5000000);
      rep_delay_q <= CfgW'(400000);
      rep_intv_q  <= CfgW'(150000);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BACK_HOLD:       back_hold_q <= cfg_data_i;
        CFG_HOME_HOLD:       home_hold_q <= cfg_data_i;
        CFG_REPEAT_DELAY:    rep_delay_q <= cfg_data_i;
        CFG_REPEAT_INTERVAL: rep_intv_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      for (int b = 0; b < 3; b++) start_q[b] <= '0;
      for (int s = 0; s < 2; s++) last_q[s] <= '0;
    end else if (accept_i) begin
      prev_q <= pressed;
      for (int b = 0; b < 3; b++) start_q[b] <= start_d[b];
      for (int s = 0; s < 2; s++) begin
        if (rep[s]) last_q[s] <= time_now_us_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/tbmn_fifo.sv
`default_nettype none

module tbmn_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tbmn_pkg::cls_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output tbmn_pkg::cls_t      rdata_o
);
  import tbmn_pkg::*;

  cls_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/tbmn_back.sv
`default_nettype none

module tbmn_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cls_valid_i,
  input  wire tbmn_pkg::cls_t cls_i,
  output logic                cls_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          button_index_o,
  output logic [3:0]          event_code_o,
  output logic [1:0]          screen_after_o,
  output logic [3:0]          menu_selection_o,
  output logic [3:0]          active_app_o,
  output logic                last_of_poll_o
);
  import tbmn_pkg::*;

  button_e    btn_q, btn_d;
  screen_e    screen_q, screen_d;
  logic [3:0] sel_q, sel_d;
  logic [3:0] app_q, app_d;
  logic       mlf_q, mlf_d, mlf_eff;
  logic       click;
  event_e     ev;
  logic       fire;
  logic       out_valid_q;
  logic [1:0] out_btn_q, out_scr_q;
  logic [3:0] out_ev_q, out_sel_q, out_app_q;

  assign fire      = cls_valid_i && (!out_valid_q || out_ready_i);
  assign cls_pop_o = fire && (btn_q == BUTTON_RIGHT);

  always_comb begin
    case (btn_q)
      BUTTON_LEFT:   btn_d = BUTTON_MIDDLE;
      BUTTON_MIDDLE: btn_d = BUTTON_RIGHT;
      default:       btn_d = BUTTON_LEFT;
    endcase
  end

  // A new middle press clears the long-hold flag before the hold is judged.
  assign mlf_eff = (cls_i.mid_pressed && !cls_i.mid_prev) ? 1'b0 : mlf_q;

  always_comb begin
    screen_d = screen_q;
    sel_d    = sel_q;
    app_d    = app_q;
    mlf_d    = mlf_q;
    ev       = EV_NONE;
    click    = 1'b0;
    case (btn_q)
      BUTTON_LEFT:  click = cls_i.left_click;
      BUTTON_RIGHT: click = cls_i.right_click;
      BUTTON_MIDDLE: begin
        mlf_d = mlf_eff;
        if (cls_i.mid_pressed && !mlf_eff && screen_q == SCREEN_HOME &&
            cls_i.mid_gt_home) begin
          mlf_d    = 1'b1;
          screen_d = SCREEN_APP;
          app_d    = AppAssist;
          ev       = EV_ASSIST;
        end else if (cls_i.mid_pressed && !mlf_eff && screen_q != SCREEN_HOME &&
                     cls_i.mid_gt_back) begin
          mlf_d = 1'b1;
          if (screen_q == SCREEN_APP) begin
            screen_d = SCREEN_MENU;
            ev       = EV_APP_MENU;
          end else if (screen_q == SCREEN_MENU) begin
            screen_d = SCREEN_HOME;
            ev       = EV_MENU_HOME;
          end
        end else begin
          click = !cls_i.mid_pressed && cls_i.mid_prev && !mlf_eff;
        end
      end
      default: ;
    endcase

    if (click) begin
      case (screen_q)
        SCREEN_HOME: begin
          screen_d = SCREEN_MENU;
          ev       = EV_HOME_MENU;
        end
        SCREEN_MENU: begin
          case (btn_q)
            BUTTON_LEFT: begin
              sel_d = (sel_q == 4'd0) ? SelLast : sel_q - 4'd1;
              ev    = EV_SEL_UP;
            end
            BUTTON_RIGHT: begin
              sel_d = (sel_q == SelLast) ? 4'd0 : sel_q + 4'd1;
              ev    = EV_SEL_DOWN;
            end
            default: begin
              app_d    = sel_q;
              screen_d = SCREEN_APP;
              ev       = EV_OPEN_SEL;
            end
          endcase
        end
        default: ev = EV_FORWARD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q       <= BUTTON_LEFT;
      screen_q    <= SCREEN_HOME;
      sel_q       <= 4'd0;
      app_q       <= 4'd0;
      mlf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        btn_q       <= btn_d;
        screen_q    <= screen_d;
        sel_q       <= sel_d;
        app_q       <= app_d;
        mlf_q       <= mlf_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_btn_q <= btn_q;
      out_ev_q  <= ev;
      out_scr_q <= screen_d;
      out_sel_q <= sel_d;
      out_app_q <= app_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign button_index_o   = out_btn_q;
  assign event_code_o     = out_ev_q;
  assign screen_after_o   = out_scr_q;
  assign menu_selection_o = out_sel_q;
  assign active_app_o     = out_app_q;
  assign last_of_poll_o   = out_btn_q == BUTTON_RIGHT;

endmodule

`default_nettype wire

// File: design/tbmn_checker.sv
`default_nettype none

module tbmn_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic [1:0] button_index_o,
  input wire logic [3:0] event_code_o,
  input wire logic [1:0] screen_after_o,
  input wire logic [3:0] menu_selection_o,
  input wire logic [3:0] active_app_o,
  input wire logic last_of_poll_o
);
  import tbmn_pkg::*;

  // A stalled result beat keeps its button index, event code and screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(button_index_o)
      && $stable(event_code_o) && $stable(screen_after_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_poll_o == (button_index_o == BUTTON_RIGHT))
      && button_index_o != 2'd3)
    else $error("button order broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o == EV_OPEN_SEL |->
      screen_after_o == SCREEN_APP && active_app_o == menu_selection_o)
    else $error("open selected did not open the highlighted app");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_code_o == EV_HOME_MENU || event_code_o == EV_APP_MENU)
      |-> screen_after_o == SCREEN_MENU)
    else $error("menu event without menu screen");

endmodule

bind three_button_menu_navigator_unit tbmn_checker u_tbmn_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tbmn_pkg::*;

  typedef struct {
    logic [TimeW-1:0] stamp;
    logic [2:0]       levels;  // bit 0 left, bit 1 middle, bit 2 right; 0 is pressed
  } poll_t;

  typedef struct {
    button_e    btn;
    event_e     ev;
    screen_e    scr;
    logic [3:0] sel;
    logic [3:0] app;
    logic       last;
  } nav_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [TimeW-1:0]    time_now_us_i = '0;
  logic                left_level_i = 1'b1;
  logic                middle_level_i = 1'b1;
  logic                right_level_i = 1'b1;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = CFG_BACK_HOLD;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          button_index_o;
  logic [3:0]          event_code_o;
  logic [1:0]          screen_after_o;
  logic [3:0]          menu_selection_o;
  logic [3:0]          active_app_o;
  logic                last_of_poll_o;

  three_button_menu_navigator_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .time_now_us_i,
    .left_level_i,
    .middle_level_i,
    .right_level_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .out_valid_o,
    .out_ready_i,
    .button_index_o,
    .event_code_o,
    .screen_after_o,
    .menu_selection_o,
    .active_app_o,
    .last_of_poll_o
  );

  always #5 clk_i = ~clk_i;

  poll_t       pending_polls[$];
  nav_result_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 31;
  logic        in_taken = 1'b0;

  // Predictor state and its copy of the registers.
  logic [CfgW-1:0]  back_hold = 24'd600000;
  logic [CfgW-1:0]  home_hold = 24'd5000000;
  logic [CfgW-1:0]  repeat_delay = 24'd400000;
  logic [CfgW-1:0]  repeat_interval = 24'd150000;
  logic [2:0]       btn_down = '0;
  logic [TimeW-1:0] press_t[3] = '{default: '0};
  logic [TimeW-1:0] repeat_t[3] = '{default: '0};
  logic             mid_fired = 1'b0;
  screen_e          scr = SCREEN_HOME;
  logic [3:0]       sel = '0;
  logic [3:0]       app = '0;

  // Stimulus generator state.
  logic [TimeW-1:0] stamp_us = 48'hFFFF_FFF0_0000;
  logic [2:0]       levels_now = 3'b111;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic event_e apply_click(button_e btn);
    case (scr)
      SCREEN_HOME: begin
        scr = SCREEN_MENU;
        return EV_HOME_MENU;
      end
      SCREEN_MENU: begin
        if (btn == BUTTON_LEFT) begin
          sel = (sel == 4'd0) ? SelLast : sel - 4'd1;
          return EV_SEL_UP;
        end
        if (btn == BUTTON_RIGHT) begin
          sel = (sel == SelLast) ? 4'd0 : sel + 4'd1;
          return EV_SEL_DOWN;
        end
        app = sel;
        scr = SCREEN_APP;
        return EV_OPEN_SEL;
      end
      default: return EV_FORWARD;
    endcase
  endfunction

  function automatic void predict_poll(logic [TimeW-1:0] now, logic [2:0] levels);
    nav_result_t      res;
    button_e          btn;
    event_e           ev;
    logic [2:0]       down;
    logic [TimeW-1:0] held;
    logic             rising;
    logic             clicked;
    down = ~levels;
    for (int b = 0; b < 3; b++) begin
      btn = button_e'(b);
      ev = EV_NONE;
      clicked = 1'b0;
      rising = down[b] && !btn_down[b];
      if (rising) begin
        press_t[b] = now;
        if (btn == BUTTON_MIDDLE) mid_fired = 1'b0;
      end
      if (btn == BUTTON_MIDDLE) begin
        held = now - press_t[b];
        if (down[b] && !mid_fired && scr == SCREEN_HOME && held > {24'd0, home_hold}) begin
          mid_fired = 1'b1;
          scr = SCREEN_APP;
          app = AppAssist;
          ev = EV_ASSIST;
        end else if (down[b] && !mid_fired && scr != SCREEN_HOME &&
                     held > {24'd0, back_hold}) begin
          mid_fired = 1'b1;
          if (scr == SCREEN_APP) begin
            scr = SCREEN_MENU;
            ev = EV_APP_MENU;
          end else begin
            scr = SCREEN_HOME;
            ev = EV_MENU_HOME;
          end
        end else if (!down[b] && btn_down[b] && !mid_fired) begin
          clicked = 1'b1;
        end
      end else begin
        if (rising) clicked = 1'b1;
        // The repeat stamp survives a release, so a new press may repeat on the delay alone.
        if (down[b] && (now - press_t[b]) > {24'd0, repeat_delay} &&
            (now - repeat_t[b]) > {24'd0, repeat_interval}) begin
          clicked = 1'b1;
          repeat_t[b] = now;
        end
      end
      btn_down[b] = down[b];
      if (clicked) ev = apply_click(btn);
      res.btn = btn;
      res.ev = ev;
      res.scr = scr;
      res.sel = sel;
      res.app = app;
      res.last = (btn == BUTTON_RIGHT);
      expected_results.push_back(res);
    end
  endfunction

  // Input beats are taken and results checked on the rising edge.
  always @(posedge clk_i) begin : monitor
    nav_result_t want;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (button_index_o !== want.btn)
          flag_mismatch($sformatf("button_index %0d, expected %0d", button_index_o, want.btn));
        if (event_code_o !== want.ev)
          flag_mismatch($sformatf("button %0d event_code %0d, expected %0d",
                                  want.btn, event_code_o, want.ev));
        if (screen_after_o !== want.scr)
          flag_mismatch($sformatf("button %0d screen_after %0d, expected %0d",
                                  want.btn, screen_after_o, want.scr));
        if (menu_selection_o !== want.sel)
          flag_mismatch($sformatf("button %0d menu_selection %0d, expected %0d",
                                  want.btn, menu_selection_o, want.sel));
        if (active_app_o !== want.app)
          flag_mismatch($sformatf("button %0d active_app %0d, expected %0d",
                                  want.btn, active_app_o, want.app));
        if (last_of_poll_o !== want.last)
          flag_mismatch($sformatf("button %0d last_of_poll %0d, expected %0d",
                                  want.btn, last_of_poll_o, want.last));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o)
      predict_poll(time_now_us_i, {right_level_i, middle_level_i, left_level_i});
  end

  always @(negedge clk_i) begin : driver
    poll_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_polls.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_polls.pop_front();
          in_valid_i <= 1'b1;
          time_now_us_i <= nxt.stamp;
          left_level_i <= nxt.levels[0];
          middle_level_i <= nxt.levels[1];
          right_level_i <= nxt.levels[2];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic void add_poll(logic [TimeW-1:0] gap, logic l, logic m, logic r);
    poll_t p;
    stamp_us += gap;
    levels_now = {r, m, l};
    p.stamp = stamp_us;
    p.levels = levels_now;
    pending_polls.push_back(p);
  endfunction

  function automatic logic [TimeW-1:0] next_gap(int unsigned scale);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return TimeW'({$urandom(), $urandom()});
    if (pick < 12) return '0;
    return TimeW'($urandom_range(scale));
  endfunction

  // Buttons mostly stay put, so presses last several polls and holds reach the thresholds.
  function automatic void add_random_polls(int n, int unsigned scale);
    logic [2:0] lv;
    for (int i = 0; i < n; i++) begin
      lv = levels_now;
      for (int b = 0; b < 3; b++)
        if ($urandom_range(99) < 22) lv[b] = ~lv[b];
      add_poll(next_gap(scale), lv[0], lv[1], lv[2]);
    end
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_polls.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_BACK_HOLD:    back_hold = val;
      CFG_HOME_HOLD:    home_hold = val;
      CFG_REPEAT_DELAY: repeat_delay = val;
      default:          repeat_interval = val;
    endcase
  endtask

  task automatic program_regs(logic [CfgW-1:0] back, logic [CfgW-1:0] home,
                              logic [CfgW-1:0] delay, logic [CfgW-1:0] interval);
    wait_drained();
    repeat (3) @(negedge clk_i);
    write_reg(CFG_BACK_HOLD, back);
    write_reg(CFG_HOME_HOLD, home);
    write_reg(CFG_REPEAT_DELAY, delay);
    write_reg(CFG_REPEAT_INTERVAL, interval);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    // Directed walk at the reset settings; the timestamp wraps partway through.
    add_poll(0, 1, 1, 1);
    add_poll(10, 0, 1, 1);          // left press on home opens the menu
    add_poll(400000, 0, 1, 1);      // held exactly the repeat delay: no repeat
    add_poll(1, 0, 1, 1);           // first repeat, selection wraps upward
    add_poll(150000, 0, 1, 1);      // exactly the repeat interval: no repeat
    add_poll(1, 0, 1, 1);
    add_poll(10, 1, 1, 0);
    add_poll(10, 1, 1, 1);
    add_poll(10, 1, 1, 0);          // selection wraps downward
    add_poll(10, 1, 1, 1);
    add_poll(10, 1, 1, 0);
    add_poll(10, 1, 0, 1);
    add_poll(10, 1, 1, 1);          // middle release opens the selected entry
    add_poll(10, 0, 1, 1);          // click inside an app is forwarded
    add_poll(10, 1, 0, 1);
    add_poll(600000, 1, 0, 1);      // exactly the back hold: nothing yet
    add_poll(1, 1, 0, 1);           // app back to menu
    add_poll(700000, 1, 0, 1);      // long hold already fired
    add_poll(10, 1, 1, 1);          // release after a long hold does not click
    add_poll(10, 1, 0, 1);
    add_poll(600001, 1, 0, 1);      // menu back to home
    add_poll(10, 1, 1, 1);
    add_poll(10, 1, 0, 1);
    add_poll(5000000, 1, 0, 1);     // exactly the home hold: nothing yet
    add_poll(1, 1, 0, 1);           // open the assistant app
    add_poll(10, 0, 0, 0);
    add_poll(10, 1, 1, 1);
    add_random_polls(60, 1500000);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_regs(24'd3000, 24'd9000, 24'd2000, 24'd700);
    add_random_polls(110, 2500);

    program_regs(24'd0, 24'd0, 24'd0, 24'd0);
    idle_pct = 0;
    add_random_polls(60, 3);

    program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    wait_drained();
    idle_pct = 31;
    add_random_polls(50, 9000000);

    program_regs(CfgW'($urandom_range(20000)), CfgW'($urandom_range(20000)),
                 CfgW'($urandom_range(20000)), CfgW'($urandom_range(20000)));
    add_random_polls(100, 15000);

    program_regs(CfgW'($urandom()), CfgW'($urandom()), CfgW'($urandom_range(60000)),
                 CfgW'($urandom_range(20000)));
    add_random_polls(70, 40000);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
